>>> rtl/spq_pkg.sv
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

>>> rtl/spq_mem.sv
module spq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  spq_pkg::value_t      wdata,
    input  logic [AW-1:0]        raddr,
    output spq_pkg::value_t      rdata
);
    import spq_pkg::*;

    value_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/sorted_insertion_priority_queue_core.sv
// Sorted priority queue of signed 32-bit values, largest first, held in one
// single-port-read RAM. Pulse start while busy is low; exactly one result
// comes back on done for one cycle and cannot be stalled. A pop reads the
// head, then moves one entry per cycle toward the head. A push walks from
// the tail, shifting each entry that is not larger back one place until the
// insert slot is found, and when it lands at the head goes through a separate
// head state that writes the value. A push into an empty queue and the errors
// (pop on empty, push on full) are settled in the idle state and reported
// through the done register. Busy is low again in the done cycle. The RAM port
// pair, one read and one write per cycle, sets the pace of the walk.
module sorted_insertion_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  spq_pkg::value_t                     value,
    output logic                                done,
    output spq_pkg::value_t                     popped_value,
    output logic [1:0]                          status,
    output logic [spq_pkg::COUNT_W-1:0]         entry_count
);
    import spq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PUSH = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_HEAD = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    value_t         val_reg, val_next;
    value_t         pop_reg, pop_next;
    logic           first_reg, first_next;
    logic           done_reg, done_next;
    logic [1:0]     status_reg, status_next;
    value_t         popv_reg, popv_next;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    value_t         wdata, rdata;

    spq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_value = popv_reg;
    assign entry_count  = COUNT_W'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        pop_next    = pop_reg;
        first_next  = 1'b0;
        done_next   = 1'b0;
        status_next = status_reg;
        popv_next   = popv_reg;
        we          = 1'b0;
        waddr       = AW'(idx_reg);
        wdata       = val_reg;
        raddr       = AW'(idx_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next = value;
                    if (mode == MODE_PUSH)
                    begin
                        if (count_reg >= CW'(DEPTH))
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_FULL;
                            popv_next   = '0;
                        end
                        else if (count_reg == '0)
                        begin
                            we          = 1'b1;
                            waddr       = '0;
                            wdata       = value;
                            count_next  = CW'(1);
                            done_next   = 1'b1;
                            status_next = STATUS_OK;
                            popv_next   = '0;
                        end
                        else
                        begin
                            idx_next   = count_reg - CW'(1);
                            raddr      = AW'(count_reg - CW'(1));
                            state_next = S_PUSH;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_EMPTY;
                            popv_next   = '0;
                        end
                        else
                        begin
                            idx_next   = '0;
                            raddr      = '0;
                            first_next = 1'b1;
                            state_next = S_POP;
                        end
                    end
                end
            end
            S_PUSH:
            begin
                // rdata holds entry idx; shift it back if not larger than the new value
                if (rdata <= val_reg)
                begin
                    we    = 1'b1;
                    waddr = AW'(idx_reg + CW'(1));
                    wdata = rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        idx_next = idx_reg - CW'(1);
                        raddr    = AW'(idx_reg - CW'(1));
                    end
                end
                else
                begin
                    we          = 1'b1;
                    waddr       = AW'(idx_reg + CW'(1));
                    wdata       = val_reg;
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    count_next  = count_reg + CW'(1);
                    status_next = STATUS_OK;
                    popv_next   = '0;
                end
            end
            S_HEAD:
            begin
                // place the new value at the head once every entry has shifted back
                we          = 1'b1;
                waddr       = '0;
                wdata       = val_reg;
                state_next  = S_IDLE;
                done_next   = 1'b1;
                count_next  = count_reg + CW'(1);
                status_next = STATUS_OK;
                popv_next   = '0;
            end
            S_POP:
            begin
                // rdata holds entry idx; move it to idx-1, head is captured
                if (first_reg)
                begin
                    pop_next = rdata;
                end
                else
                begin
                    we    = 1'b1;
                    waddr = AW'(idx_reg - CW'(1));
                    wdata = rdata;
                end
                if (idx_reg + CW'(1) >= count_reg)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    count_next  = count_reg - CW'(1);
                    status_next = STATUS_OK;
                    popv_next   = first_reg ? rdata : pop_reg;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    raddr    = AW'(idx_reg + CW'(1));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            first_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            first_reg   <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        pop_reg    <= pop_next;
        status_reg <= status_next;
        popv_reg   <= popv_next;
    end

endmodule

>>> tb/tb_sorted_insertion_priority_queue_core.sv
module tb_sorted_insertion_priority_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    class queue_scoreboard;
        value_t      held[$];
        value_t      exp_value[$];
        logic [1:0]  exp_status[$];
        int unsigned exp_count[$];
        int          errors;

        function void note_transfer(logic op, value_t v);
            int pos;
            value_t pv;
            logic [1:0] st;
            pv = '0;
            st = STATUS_OK;
            if (op == MODE_PUSH)
            begin
                if (held.size() >= DEPTH)
                begin
                    st = STATUS_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < held.size() && v < held[pos])
                        pos++;
                    held.insert(pos, v);
                end
            end
            else
            begin
                if (held.size() == 0)
                begin
                    st = STATUS_EMPTY;
                end
                else
                begin
                    pv = held.pop_front();
                end
            end
            exp_value.push_back(pv);
            exp_status.push_back(st);
            exp_count.push_back(held.size());
        endfunction

        function void check_result(value_t pv, logic [1:0] st, logic [COUNT_W-1:0] cnt);
            value_t ev;
            logic [1:0] es;
            logic [COUNT_W-1:0] ec;
            if (exp_value.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %0d/%0d/%0d",
                         $time, pv, st, cnt);
                errors++;
                return;
            end
            ev = exp_value.pop_front();
            es = exp_status.pop_front();
            ec = COUNT_W'(exp_count.pop_front());
            if (pv !== ev)
            begin
                $display("%0t: popped_value expected %0d actual %0d", $time, ev, pv);
                errors++;
            end
            if (st !== es)
            begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (cnt !== ec)
            begin
                $display("%0t: entry_count expected %0d actual %0d", $time, ec, cnt);
                errors++;
            end
        endfunction

        function int pending();
            return exp_value.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               mode = MODE_PUSH;
    value_t             value = '0;
    logic               busy;
    logic               done;
    value_t             popped_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;

    queue_scoreboard sb = new();
    int unsigned cycles = 0;

    sorted_insertion_priority_queue_core #(.DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .value(value), .done(done), .popped_value(popped_value),
        .status(status), .entry_count(entry_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_sorted_insertion_priority_queue_core: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(popped_value, status, entry_count);
    end

    task automatic send_op(logic op, value_t v, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            mode  <= 1'($urandom_range(0, 1));
            value <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode  <= op;
        value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_transfer(op, v);
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 7) - 3;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int n;
        int k;
        int fill;
        bit gaps;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(MODE_POP, 32'sh7fffffff, 0);
        send_op(MODE_PUSH, 32'sh80000000, 0);
        send_op(MODE_PUSH, 32'sh7fffffff, 0);
        send_op(MODE_PUSH, 32'sd0, 0);
        send_op(MODE_PUSH, 32'sd0, 0);
        send_op(MODE_PUSH, -32'sd1, 0);
        send_op(MODE_PUSH, 32'sh55555555, 0);
        send_op(MODE_PUSH, 32'shaaaaaaaa, 0);
        for (int i = 0; i < 10; i++)
            send_op(MODE_PUSH, 32'sh7fffffff - i, 0);
        send_op(MODE_PUSH, 32'sd5, 0);
        repeat (17) send_op(MODE_POP, 32'sd0, 0);

        n = 0;
        while (n < 1500)
        begin
            gaps = ($urandom_range(0, 3) != 0);
            fill = $urandom_range(0, 2);
            k = $urandom_range(5, 20);
            if (fill == 0)
            begin
                repeat (k) send_op(MODE_PUSH, pick_value(), gaps);
                n += k;
            end
            else if (fill == 1)
            begin
                repeat (k) send_op(MODE_POP, $urandom, gaps);
                n += k;
            end
            else
            begin
                repeat (20) send_op(1'($urandom_range(0, 1)), pick_value(), gaps);
                n += 20;
            end
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_sorted_insertion_priority_queue_core: clean");
        else
            $display("tb_sorted_insertion_priority_queue_core: errors");
        $finish;
    end
endmodule
